// ===== hw/rtl/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 32;

  // Window length register and its derived widths
  localparam int CFG_W  = 6;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W  = AGE_W;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_WINDOW_LEN = '0;
  localparam logic [CFG_W-1:0]   WINDOW_LEN_RESET = CFG_W'(3);

  // What one cell shows its neighbors
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [AGE_W-1:0]              age;
    logic                          valid;
    logic                          le;     // valid and value <= incoming sample
  } swm_tap_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             step;
    logic             clear;
    logic             full;
    logic [AGE_W-1:0] oldest_age;
  } swm_ctl_t;

  localparam swm_tap_t TAP_BELOW_FIRST = '{value: '0, age: '0, valid: 1'b1, le: 1'b1};
  localparam swm_tap_t TAP_ABOVE_LAST  = '{value: '0, age: '0, valid: 1'b0, le: 1'b0};

endpackage

// ===== hw/rtl/swm_sample_if.sv =====
`timescale 1ns / 1ps

interface swm_sample_if import swm_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/swm_median_if.sv =====
`timescale 1ns / 1ps

interface swm_median_if import swm_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== hw/rtl/sliding_window_median_unit.sv =====
`timescale 1ns / 1ps

// Running lower median over the last window_len samples of a signed stream.
// Samples sit in a chain of MAX_WINDOW cells kept in ascending order; each
// cell also keeps the age of its sample. An accepted item updates the whole
// chain together: the cell holding the oldest sample drops out, the cells
// above it close the gap, and the new sample is slotted in at its sorted place,
// every cell taking its value from itself or a direct neighbor. One item is
// accepted per cycle unless input is held off; its median is read from the
// middle cell into the output register after the chain update, once that
// register is free. Input is held off only while a median waits in the
// output register and a second one is already pending behind it. From the
// window_len-th item after reset or after a write of window_len, each item
// gives one median (element (window_len-1)/2 in ascending order); earlier
// items give none. window_len 0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW. Writing window_len empties the window. No clearing pass follows
// reset. Register map: window_len at byte address 0.

module sliding_window_median_unit import swm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  swm_sample_if.sink          in_ch,
  swm_median_if.source        out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Configuration
  logic [CFG_W-1:0] window_len;
  logic [LEN_W-1:0] eff_len;
  logic             reg_hit;
  logic             cfg_write;

  // Window bookkeeping
  logic [LEN_W-1:0] fill;
  logic             full;
  logic             produces;
  logic             step;
  logic             pend;
  logic             load;
  logic [IDX_W-1:0] mid_idx;

  // Cell chain
  swm_ctl_t                ctl;
  swm_tap_t                taps  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   evict;
  logic [MAX_WINDOW-1:0]   shift;
  logic [MAX_WINDOW-1:0]   valid_vec;

  // APB port: single register, always ready
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[PADDR_W-1:2] == REG_WINDOW_LEN);
  assign cfg_write = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? PDATA_W'(window_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_write) begin
      window_len <= pwdata[CFG_W-1:0];
    end
  end

  // Clamp the length to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_len);
    end
  end

  assign full     = (fill == eff_len);
  assign produces = full || ((fill + LEN_W'(1)) == eff_len);
  assign mid_idx  = IDX_W'((eff_len - LEN_W'(1)) >> 1);

  // Hold input while a pending median cannot move into the output register
  assign in_ch.ready = !(pend && out_ch.valid && !out_ch.ready);
  assign step        = in_ch.valid && in_ch.ready;
  assign load        = pend && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_write) begin
      fill <= '0;
    end else if (step && !full) begin
      fill <= fill + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (step) begin
      pend <= produces;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  assign ctl.step       = step;
  assign ctl.clear      = cfg_write;
  assign ctl.full       = full;
  assign ctl.oldest_age = AGE_W'(eff_len - LEN_W'(1));

  // A cell closes the gap when the evicted entry sits at or below it
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      shift[i]     = |(evict & ({MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - i)));
      valid_vec[i] = taps[i].valid;
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swm_tap_t up_tap;
    swm_tap_t down_tap;
    logic     shift_low;

    if (g == MAX_WINDOW - 1) begin : g_top
      assign up_tap = TAP_ABOVE_LAST;
    end else begin : g_mid_up
      assign up_tap = taps[g + 1];
    end

    if (g == 0) begin : g_bottom
      assign down_tap  = TAP_BELOW_FIRST;
      assign shift_low = 1'b0;
    end else begin : g_mid_down
      assign down_tap  = taps[g - 1];
      assign shift_low = shift[g - 1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sample     (in_ch.sample),
      .shift_self (shift[g]),
      .shift_low  (shift_low),
      .up         (up_tap),
      .down       (down_tap),
      .tap        (taps[g]),
      .evict      (evict[g])
    );
  end

  // Output register: take the middle cell once the chain has settled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.median <= taps[mid_idx].value;
    end
  end

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill <= eff_len)
    else $error("fill count above window length");

  a_cells_match_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("occupied cells disagree with fill count");

  a_single_evict: assert property (@(posedge clk) disable iff (rst)
    $onehot0(evict))
    else $error("more than one cell evicted");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (step && full) |-> $onehot(evict))
    else $error("full window step without an evicted cell");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (pend && out_ch.valid && !out_ch.ready) |=> (pend && out_ch.valid))
    else $error("pending median lost during stall");
`endif

endmodule

// ===== hw/rtl/swm_cell.sv =====
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          shift_self,
  input  logic                          shift_low,
  input  swm_tap_t                      up,
  input  swm_tap_t                      down,
  output swm_tap_t                      tap,
  output logic                          evict
);

  logic signed [SAMPLE_BITS-1:0] value;
  logic [AGE_W-1:0]              age;
  logic                          valid;

  swm_tap_t                      prim;
  swm_tap_t                      lowr;
  logic signed [SAMPLE_BITS-1:0] value_next;
  logic [AGE_W-1:0]              age_next;
  logic                          valid_next;

  assign tap.value = value;
  assign tap.age   = age;
  assign tap.valid = valid;
  assign tap.le    = valid && (value <= sample);

  assign evict = valid && ctl.full && (age == ctl.oldest_age);

  // Close the gap left by the evicted entry, then slot the new sample in
  always_comb begin
    prim = shift_self ? up : tap;
    lowr = shift_low ? tap : down;
    if (prim.le) begin
      value_next = prim.value;
      age_next   = prim.age + AGE_W'(1);
      valid_next = 1'b1;
    end else if (lowr.le) begin
      value_next = sample;
      age_next   = '0;
      valid_next = 1'b1;
    end else begin
      value_next = lowr.value;
      age_next   = lowr.age + AGE_W'(1);
      valid_next = lowr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.step) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule
